// ----- hdl/acar_pkg.sv -----
// Package for the fully associative cache with age replacement.
// Types, constants and address helpers shared by controller, datapath and top.
package acar_pkg;

  localparam int unsigned Lines     = 5;
  localparam int unsigned LineWords = 10;
  localparam int unsigned MemWords  = 128;
  localparam int unsigned WordBits  = 16;

  localparam int unsigned LineBits  = $clog2(Lines);
  localparam int unsigned OffBits   = $clog2(LineWords);
  localparam int unsigned AddrBits  = 7;
  localparam int unsigned TagBits   = 4;
  localparam int unsigned MemAddrBits = $clog2(MemWords);
  localparam int unsigned CacheWords  = Lines * LineWords;
  localparam int unsigned CacheAddrBits = $clog2(CacheWords);
  localparam int unsigned WideBits  = TagBits + OffBits + 1;

  // address / LineWords as (address * TagRecip) >> TagShift, exact for 7-bit addresses
  localparam int unsigned TagRecip  = 205;
  localparam int unsigned TagShift  = 11;

  localparam logic [7:0] AgeMax     = 8'd255;
  localparam logic [3:0] HitTicks   = 4'd2;
  localparam logic [3:0] MissTicks  = 4'd10;

  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_FLUSH   = 3'd2,
    OP_MEM_WR  = 3'd3,
    OP_MEM_RD  = 3'd4,
    OP_UPDATE  = 3'd5,
    OP_RSVD6   = 3'd6,
    OP_RSVD7   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_MISS   = 2'd1,
    ST_DONE   = 2'd2,
    ST_NOLINE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_WB_RD,
    S_WB_WR,
    S_RF_RD,
    S_RF_WR,
    S_ACCESS,
    S_FL_RD,
    S_FL_WR,
    S_MEM_RD,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic                load;        // latch input word
    logic                lookup;      // register hit/victim results
    logic                clr_cnt;
    logic                inc_cnt;
    logic                sel_line;    // line counter used as line for flush
    logic                next_line;
    logic                cache_rd;    // read cache word at (line, cnt)
    logic                mem_wr_wb;   // write cache read data to mem
    logic                mem_rd_rf;   // read mem for refill
    logic                cache_wr_rf; // write mem data into cache
    logic                set_tag;
    logic                touch;
    logic                access;      // read/write word at offset
    logic                mem_wr_bd;
    logic                mem_rd_bd;
    logic                update;
    logic                finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic       hit;
    logic       vic_valid;
    logic       cnt_last;
    logic       line_last;
    logic       line_valid;
  } stat_t;

endpackage

// ----- hdl/assoc_cache_age_replacement.sv -----
// Top level of the fully associative write-back cache with age replacement.
// Instantiates acar_ctrl and acar_dp; uses acar_pkg.
//
// One command word is taken when start_i is high and busy_o is low; one result
// word follows on a one-cycle done_o strobe, which the receiver cannot stall.
// A miss refills the victim line word by word from backing memory, first writing
// each word of a valid victim back; flush all writes back every valid line word
// by word. A new command can be taken in the done_o cycle. The single-port line
// store and backing memory give each word of write-back and refill a read step
// and a write step.
module assoc_cache_age_replacement import acar_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  opcode_i,
  input  logic [6:0]  address_i,
  input  logic [15:0] write_value_i,
  output logic        done_o,
  output logic [15:0] read_data_o,
  output logic [1:0]  status_o,
  output logic [3:0]  penalty_ticks_o
);

  cmd_t  cmd;
  stat_t stat;

  acar_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start_i),
    .busy   (busy_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  acar_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .opcode_i        (opcode_i),
    .address_i       (address_i),
    .write_value_i   (write_value_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .done_o          (done_o),
    .read_data_o     (read_data_o),
    .status_o        (status_o),
    .penalty_ticks_o (penalty_ticks_o)
  );

endmodule

// ----- hdl/acar_ctrl.sv -----
// Controller state machine of the cache: sequences lookup, write-back,
// refill, flush walk, cell updates and backdoor accesses. Uses acar_pkg.
module acar_ctrl import acar_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup  = 1'b1;
        cmd_o.clr_cnt = 1'b1;
        unique case (op_e'(stat_i.op))
          OP_READ, OP_WRITE: state_d = S_ACCESS;
          OP_FLUSH:  state_d = S_FL_RD;
          OP_MEM_WR: begin
            cmd_o.mem_wr_bd = 1'b1;
            state_d = S_DONE;
          end
          OP_MEM_RD: begin
            cmd_o.mem_rd_bd = 1'b1;
            state_d = S_MEM_RD;
          end
          OP_UPDATE: begin
            cmd_o.update = 1'b1;
            state_d = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
        // miss path decided next cycle from registered lookup
        if (stat_i.op == OP_READ || stat_i.op == OP_WRITE) state_d = S_WB_RD;
      end
      S_WB_RD: begin
        if (stat_i.hit) begin
          state_d = S_ACCESS;
        end else if (stat_i.vic_valid) begin
          cmd_o.cache_rd = 1'b1;
          state_d = S_WB_WR;
        end else begin
          state_d = S_RF_RD;
        end
      end
      S_WB_WR: begin
        cmd_o.mem_wr_wb = 1'b1;
        cmd_o.inc_cnt   = 1'b1;
        if (stat_i.cnt_last) begin
          cmd_o.clr_cnt = 1'b1;
          cmd_o.inc_cnt = 1'b0;
          state_d = S_RF_RD;
        end else begin
          state_d = S_WB_RD;
        end
      end
      S_RF_RD: begin
        cmd_o.mem_rd_rf = 1'b1;
        state_d = S_RF_WR;
      end
      S_RF_WR: begin
        cmd_o.cache_wr_rf = 1'b1;
        cmd_o.inc_cnt     = 1'b1;
        if (stat_i.cnt_last) begin
          cmd_o.clr_cnt = 1'b1;
          cmd_o.inc_cnt = 1'b0;
          cmd_o.set_tag = 1'b1;
          state_d = S_ACCESS;
        end else begin
          state_d = S_RF_RD;
        end
      end
      S_ACCESS: begin
        cmd_o.access = 1'b1;
        cmd_o.touch  = 1'b1;
        state_d = S_DONE;
      end
      S_FL_RD: begin
        cmd_o.sel_line = 1'b1;
        if (stat_i.line_valid) begin
          cmd_o.cache_rd = 1'b1;
          state_d = S_FL_WR;
        end else if (stat_i.line_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.next_line = 1'b1;
        end
      end
      S_FL_WR: begin
        cmd_o.sel_line  = 1'b1;
        cmd_o.mem_wr_wb = 1'b1;
        cmd_o.inc_cnt   = 1'b1;
        state_d = S_FL_RD;
        if (stat_i.cnt_last) begin
          cmd_o.inc_cnt = 1'b0;
          cmd_o.clr_cnt = 1'b1;
          if (stat_i.line_last) begin
            state_d = S_DONE;
          end else begin
            cmd_o.next_line = 1'b1;
          end
        end
      end
      S_MEM_RD: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/acar_dp.sv -----
// Datapath of the cache: line store, backing memory, tags, ages, counters
// and the result register. Uses acar_pkg.
module acar_dp import acar_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          opcode_i,
  input  logic [AddrBits-1:0] address_i,
  input  logic [15:0]         write_value_i,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  output logic                done_o,
  output logic [15:0]         read_data_o,
  output logic [1:0]          status_o,
  output logic [3:0]          penalty_ticks_o
);

  logic [2:0]          op_q;
  logic [AddrBits-1:0] addr_q;
  logic [WordBits-1:0] val_q;
  logic [TagBits-1:0]  tag_q;
  logic [OffBits-1:0]  off_q;

  logic [WordBits-1:0] cache_mem [CacheWords];
  logic [WordBits-1:0] back_mem  [MemWords];
  logic [CacheWords-1:0] cw_valid_q; // cleared words read as zero
  logic [MemWords-1:0]   mw_valid_q;

  logic [TagBits-1:0]  tag_r_q [Lines];
  logic [Lines-1:0]    valid_q;
  logic [7:0]          age_q [Lines];

  logic                hit_q;
  logic [LineBits-1:0] line_q;   // hit or victim line
  logic [LineBits-1:0] fline_q;  // flush line counter
  logic [OffBits-1:0]  cnt_q;

  logic [WordBits-1:0] crd_q;
  logic [WordBits-1:0] mrd_q;

  logic [15:0]         rdata_q;
  logic [1:0]          status_q;
  logic [3:0]          ticks_q;
  logic                done_q;

  // tag and offset of the incoming address by reciprocal multiplication
  logic [AddrBits+7:0] tag_prod;
  logic [TagBits-1:0]  tag_c;
  logic [OffBits-1:0]  off_c;

  assign tag_prod = (AddrBits+8)'(address_i) * (AddrBits+8)'(TagRecip);
  assign tag_c    = tag_prod[TagShift +: TagBits];
  assign off_c    = OffBits'(address_i - AddrBits'(tag_c * LineWords));

  // combinational lookup over the small tag set
  logic                hit_c;
  logic [LineBits-1:0] hit_idx_c;
  logic [LineBits-1:0] vic_c;
  logic [7:0]          top_c;

  always_comb begin
    hit_c = 1'b0;
    hit_idx_c = '0;
    for (int i = Lines - 1; i >= 0; i--) begin
      if (valid_q[i] && tag_r_q[i] == tag_q) begin
        hit_c = 1'b1;
        hit_idx_c = LineBits'(i);
      end
    end
    vic_c = '0;
    top_c = '0;
    for (int i = 0; i < Lines; i++) begin
      if (age_q[i] > top_c) begin
        top_c = age_q[i];
        vic_c = LineBits'(i);
      end
    end
  end

  logic [LineBits-1:0]      cur_line;
  logic [TagBits-1:0]       cur_tag;
  logic [CacheAddrBits-1:0] cw_idx;
  logic [CacheAddrBits-1:0] acc_idx;
  logic [WideBits-1:0]      wb_addr;
  logic [WideBits-1:0]      rf_addr;
  logic                     wb_in;
  logic                     rf_in;
  logic                     bd_in;

  assign cur_line = cmd_i.sel_line ? fline_q : line_q;
  assign cur_tag  = tag_r_q[cur_line];
  assign cw_idx   = CacheAddrBits'(cur_line * LineWords + cnt_q);
  assign acc_idx  = CacheAddrBits'(line_q * LineWords + off_q);
  assign wb_addr  = WideBits'(cur_tag * LineWords + cnt_q);
  assign rf_addr  = WideBits'(tag_q * LineWords + cnt_q);
  assign wb_in    = wb_addr < WideBits'(MemWords);
  assign rf_in    = rf_addr < WideBits'(MemWords);
  assign bd_in    = {1'b0, addr_q} < (AddrBits + 1)'(MemWords);

  // valid bits model the all-zero reset of both stores
  logic                     crd_v_q;
  logic                     mrd_v_q;
  logic [WordBits-1:0]      crd_eff;
  logic [WordBits-1:0]      mrd_eff;
  assign crd_eff = crd_v_q ? crd_q : '0;
  assign mrd_eff = mrd_v_q ? mrd_q : '0;

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.cache_rd) begin
      crd_q <= cache_mem[cw_idx];
    end else if (cmd_i.access) begin
      crd_q <= cache_mem[acc_idx];
    end
    if (cmd_i.cache_wr_rf) begin
      cache_mem[cw_idx] <= mrd_eff;
    end else if ((cmd_i.access && op_q == OP_WRITE) || (cmd_i.update && hit_c)) begin
      cache_mem[cmd_i.update ? CacheAddrBits'(hit_idx_c * LineWords + off_q) : acc_idx]
        <= val_q;
    end
    if (cmd_i.mem_rd_rf) begin
      mrd_q <= rf_in ? back_mem[MemAddrBits'(rf_addr)] : '0;
    end else if (cmd_i.mem_rd_bd) begin
      mrd_q <= bd_in ? back_mem[MemAddrBits'(addr_q)] : '0;
    end
    if (cmd_i.mem_wr_wb && wb_in) begin
      back_mem[MemAddrBits'(wb_addr)] <= crd_eff;
    end else if (cmd_i.mem_wr_bd && bd_in) begin
      back_mem[MemAddrBits'(addr_q)] <= val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_valid_q <= '0;
      mw_valid_q <= '0;
      crd_v_q    <= 1'b0;
      mrd_v_q    <= 1'b0;
    end else begin
      if (cmd_i.cache_rd) crd_v_q <= cw_valid_q[cw_idx];
      else if (cmd_i.access) crd_v_q <= cw_valid_q[acc_idx];
      if (cmd_i.mem_rd_rf) mrd_v_q <= rf_in && mw_valid_q[MemAddrBits'(rf_addr)];
      else if (cmd_i.mem_rd_bd) mrd_v_q <= bd_in && mw_valid_q[MemAddrBits'(addr_q)];
      if (cmd_i.cache_wr_rf) begin
        cw_valid_q[cw_idx] <= 1'b1;
      end else if (cmd_i.access && op_q == OP_WRITE) begin
        cw_valid_q[acc_idx] <= 1'b1;
      end else if (cmd_i.update && hit_c) begin
        cw_valid_q[CacheAddrBits'(hit_idx_c * LineWords + off_q)] <= 1'b1;
      end
      if (cmd_i.mem_wr_wb && wb_in) begin
        mw_valid_q[MemAddrBits'(wb_addr)] <= 1'b1;
      end else if (cmd_i.mem_wr_bd && bd_in) begin
        mw_valid_q[MemAddrBits'(addr_q)] <= 1'b1;
      end
    end
  end

  // control and line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      hit_q    <= 1'b0;
      line_q   <= '0;
      fline_q  <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      op_q     <= '0;
      for (int i = 0; i < Lines; i++) begin
        tag_r_q[i] <= '0;
        age_q[i]   <= '0;
      end
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.load) begin
        op_q    <= opcode_i;
        fline_q <= '0;
      end
      if (cmd_i.lookup) begin
        hit_q  <= hit_c;
        line_q <= hit_c ? hit_idx_c : vic_c;
      end
      if (cmd_i.clr_cnt) cnt_q <= '0;
      else if (cmd_i.inc_cnt) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.next_line) fline_q <= fline_q + 1'b1;
      if (cmd_i.set_tag) begin
        tag_r_q[line_q] <= tag_q;
        valid_q[line_q] <= 1'b1;
      end
      if (cmd_i.touch) begin
        for (int i = 0; i < Lines; i++) begin
          if (LineBits'(i) == line_q) age_q[i] <= '0;
          else if (age_q[i] < AgeMax) age_q[i] <= age_q[i] + 8'd1;
        end
      end
    end
  end

  // input word and results
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= address_i;
      val_q  <= write_value_i;
      tag_q  <= tag_c;
      off_q  <= off_c;
    end
    if (cmd_i.load) begin
      rdata_q  <= '0;
      status_q <= ST_DONE;
      ticks_q  <= '0;
    end
    if (cmd_i.lookup && (op_q == OP_READ || op_q == OP_WRITE)) begin
      status_q <= hit_c ? ST_HIT : ST_MISS;
      ticks_q  <= hit_c ? HitTicks : MissTicks;
    end
    if (cmd_i.update && !hit_c) status_q <= ST_NOLINE;
    if (cmd_i.finish && op_q == OP_READ) rdata_q <= crd_eff;
    if (cmd_i.finish && op_q == OP_MEM_RD) rdata_q <= mrd_eff;
  end

  assign stat_o.op         = op_q;
  assign stat_o.hit        = hit_q;
  assign stat_o.vic_valid  = valid_q[line_q];
  assign stat_o.cnt_last   = (cnt_q == OffBits'(LineWords - 1));
  assign stat_o.line_last  = (fline_q == LineBits'(Lines - 1));
  assign stat_o.line_valid = valid_q[fline_q];

  assign done_o          = done_q;
  assign read_data_o     = rdata_q;
  assign status_o        = status_q;
  assign penalty_ticks_o = ticks_q;

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for assoc_cache_age_replacement: directed and random command words
// checked against an in-bench cache predictor held by a small scoreboard class.
// Depends on acar_pkg and the RTL top level only.
module tb_top;
  import acar_pkg::*;

  class cache_scoreboard;
    typedef struct {
      logic [15:0] read_data;
      status_e     status;
      logic [3:0]  ticks;
    } cache_result_t;

    logic [15:0]   words [Lines][LineWords];
    int unsigned   tags  [Lines];
    bit            valid [Lines];
    logic [7:0]    ages  [Lines];
    logic [15:0]   mem   [MemWords];
    cache_result_t expected_words[$];
    int unsigned   errors, hits, misses, no_lines, checked;

    function new();
      foreach (words[i, j]) words[i][j] = '0;
      foreach (tags[i]) begin
        tags[i] = 0;
        valid[i] = 0;
        ages[i] = '0;
      end
      foreach (mem[i]) mem[i] = '0;
    endfunction

    function int find_line(int unsigned tag);
      for (int i = 0; i < Lines; i++)
        if (valid[i] && tags[i] == tag) return i;
      return -1;
    endfunction

    function void write_back(int unsigned ln);
      int unsigned a;
      if (!valid[ln]) return;
      for (int j = 0; j < LineWords; j++) begin
        a = tags[ln] * LineWords + j;
        if (a < MemWords) mem[a] = words[ln][j];
      end
    endfunction

    function void note_command(op_e op, logic [6:0] addr, logic [15:0] val);
      cache_result_t r;
      int unsigned tag, off, ln, a;
      int found;
      logic [7:0] top;
      tag = addr / LineWords;
      off = addr % LineWords;
      r.read_data = '0;
      r.status = ST_DONE;
      r.ticks = '0;
      case (op)
        OP_READ, OP_WRITE: begin
          found = find_line(tag);
          if (found >= 0) begin
            ln = found;
            r.status = ST_HIT;
            r.ticks = HitTicks;
          end else begin
            // victim: first line with the greatest age
            ln = 0;
            top = '0;
            for (int i = 0; i < Lines; i++)
              if (ages[i] > top) begin
                top = ages[i];
                ln = i;
              end
            write_back(ln);
            for (int j = 0; j < LineWords; j++) begin
              a = tag * LineWords + j;
              words[ln][j] = (a < MemWords) ? mem[a] : '0;
            end
            tags[ln] = tag;
            valid[ln] = 1;
            r.status = ST_MISS;
            r.ticks = MissTicks;
          end
          for (int i = 0; i < Lines; i++)
            if (ages[i] != AgeMax) ages[i]++;
          ages[ln] = '0;
          if (op == OP_READ) r.read_data = words[ln][off];
          else words[ln][off] = val;
        end
        OP_FLUSH: for (int i = 0; i < Lines; i++) write_back(i);
        OP_MEM_WR: if (addr < MemWords) mem[addr] = val;
        OP_MEM_RD: r.read_data = (addr < MemWords) ? mem[addr] : '0;
        OP_UPDATE: begin
          found = find_line(tag);
          if (found >= 0) words[found][off] = val;
          else r.status = ST_NOLINE;
        end
        default: ;
      endcase
      expected_words.push_back(r);
    endfunction

    function void check_word(logic [15:0] rd, logic [1:0] st, logic [3:0] pt);
      cache_result_t r;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: data %h status %0d ticks %0d",
               rd, st, pt);
        errors++;
        return;
      end
      r = expected_words.pop_front();
      checked++;
      case (r.status)
        ST_HIT: hits++;
        ST_MISS: misses++;
        ST_NOLINE: no_lines++;
        default: ;
      endcase
      if (rd !== r.read_data) begin
        $error("read_data: expected %h, got %h", r.read_data, rd);
        errors++;
      end
      if (st !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, st);
        errors++;
      end
      if (pt !== r.ticks) begin
        $error("penalty_ticks: expected %0d, got %0d", r.ticks, pt);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned StallLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [2:0]  opcode_i = '0;
  logic [6:0]  address_i = '0;
  logic [15:0] write_value_i = '0;
  logic        busy_o, done_o;
  logic [15:0] read_data_o;
  logic [1:0]  status_o;
  logic [3:0]  penalty_ticks_o;

  cache_scoreboard ledger = new();
  int unsigned idle_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sent = 0;

  assoc_cache_age_replacement uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .address_i, .write_value_i,
    .done_o, .read_data_o, .status_o, .penalty_ticks_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result checks and the no-progress watchdog
  always @(posedge clk_i) begin
    if (rst_ni && done_o) ledger.check_word(read_data_o, status_o, penalty_ticks_o);
    if (rst_ni && ((start_i && !busy_o) || done_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", StallLimit);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_word(op_e op, logic [6:0] addr, logic [15:0] val);
    int unsigned gap;
    start_i <= 1'b1;
    opcode_i <= op;
    address_i <= addr;
    write_value_i <= val;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    ledger.note_command(op, addr, val);
    sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [6:0] pick_address();
    int unsigned a;
    if ($urandom_range(0, 99) < 70) begin
      // small working set, one more tag than lines
      a = $urandom_range(0, 5) * LineWords + $urandom_range(0, LineWords - 1);
      if ($urandom_range(0, 9) == 0) a = $urandom_range(120, 127);
      return a[6:0];
    end
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic random_word();
    int unsigned r;
    op_e op;
    r = $urandom_range(0, 99);
    if (r < 40) op = OP_READ;
    else if (r < 68) op = OP_WRITE;
    else if (r < 74) op = OP_FLUSH;
    else if (r < 81) op = OP_MEM_WR;
    else if (r < 88) op = OP_MEM_RD;
    else if (r < 96) op = OP_UPDATE;
    else op = r[0] ? OP_RSVD7 : OP_RSVD6;
    send_word(op, pick_address(), 16'($urandom()));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: cold misses, edges of fields, no-line update, backdoor, flush
    send_word(OP_READ, 7'd0, 16'h0000);
    send_word(OP_WRITE, 7'd127, 16'hFFFF);
    send_word(OP_READ, 7'd127, 16'h0000);
    send_word(OP_UPDATE, 7'd50, 16'h1234);
    send_word(OP_UPDATE, 7'd125, 16'hA5A5);
    send_word(OP_MEM_WR, 7'd0, 16'hFFFF);
    send_word(OP_MEM_RD, 7'd0, 16'h0000);
    send_word(OP_MEM_RD, 7'd127, 16'h0000);
    send_word(OP_FLUSH, 7'd0, 16'h0000);
    send_word(OP_MEM_RD, 7'd127, 16'h0000);
    send_word(OP_RSVD6, 7'd127, 16'hFFFF);
    send_word(OP_RSVD7, 7'd0, 16'h5555);
    for (int t = 1; t <= 6; t++) send_word(OP_WRITE, 7'(t * 10 + 9), 16'(t * 16'h1111));
    send_word(OP_READ, 7'd0, 16'h0000);
    send_word(OP_READ, 7'd127, 16'h0000);
    send_word(OP_FLUSH, 7'd0, 16'h0000);
    send_word(OP_MEM_RD, 7'd19, 16'h0000);
    drain();

    // hot line long enough to saturate the other ages
    for (int k = 0; k < 270; k++) send_word(OP_READ, 7'd3, 16'h0000);
    send_word(OP_READ, 7'd99, 16'h0000);
    send_word(OP_READ, 7'd117, 16'h0000);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 51 : (ph == 3) ? 26 : 0;
      for (int k = 0; k < 280; k++) random_word();
      drain();
    end

    while (ledger.expected_words.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d commands, %0d results: %0d hits, %0d misses, %0d no-line updates",
             sent, ledger.checked, ledger.hits, ledger.misses, ledger.no_lines);
    if (ledger.errors == 0 && ledger.expected_words.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
